FILE: rtl/sha1_keyed_challenge_response_defines.svh
// Assertion macros shared by the keyed SHA-1 challenge/response block.
`ifndef SHA1_KEYED_CHALLENGE_RESPONSE_DEFINES_SVH
`define SHA1_KEYED_CHALLENGE_RESPONSE_DEFINES_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SKCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skcr assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define SKCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skcr assertion failed");

`endif

FILE: rtl/skcr_pkg.sv
// Types, constants and helper functions for the keyed SHA-1 challenge/response block.
package skcr_pkg;

   localparam int NumKeyWords   = 4;
   localparam int NumMsgWords   = 5;
   localparam int CsrIndexWidth = 3;

   typedef logic [31:0] word_type;
   typedef logic [NumKeyWords-1:0][31:0] key_type;
   typedef logic [NumMsgWords-1:0][31:0] chain_type;
   typedef logic [6:0] round_type;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_WORD3 = 3'd3;

   localparam key_type KeyReset = {32'h76543210, 32'hFEDCBA98, 32'h89ABCDEF, 32'h01234567};

   localparam chain_type InitChain = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                      32'hEFCDAB89, 32'h67452301};

   localparam word_type PadWord    = 32'h80000000;
   localparam word_type LengthWord = 32'h00000120;

   localparam round_type LastRound      = 7'd79;
   localparam round_type ParityStart    = 7'd20;
   localparam round_type MajorityStart  = 7'd40;
   localparam round_type LateStart      = 7'd60;

   typedef enum logic [1:0] {
      PHASE_CHOOSE,
      PHASE_PARITY,
      PHASE_MAJORITY,
      PHASE_PARITY_LATE
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the schedule window and the round unit.
   typedef struct packed {
      logic      load;
      logic      step;
      phase_type phase;
   } ctrl_type;

   function automatic word_type round_constant(input phase_type phase);
      word_type k;
      case (phase)
         PHASE_CHOOSE:      k = 32'h5A827999;
         PHASE_PARITY:      k = 32'h6ED9EBA1;
         PHASE_MAJORITY:    k = 32'h8F1BBCDC;
         PHASE_PARITY_LATE: k = 32'hCA62C1D6;
         default:           k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/skcr_schedule.sv
// Sixteen-word message schedule window, shifted once per round.
module skcr_schedule (
   input  logic                clock,
   input  skcr_pkg::ctrl_type  ctrl,
   input  skcr_pkg::key_type   key,
   input  skcr_pkg::chain_type msg,
   output skcr_pkg::word_type  sched_word
);

   skcr_pkg::word_type win_ff [16];
   skcr_pkg::word_type win_in [16];
   skcr_pkg::word_type mix;
   skcr_pkg::word_type next_word;

   // Entry i holds the schedule word of the round i places ahead.
   assign mix       = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign next_word = {mix[30:0], mix[31]};
   assign sched_word = win_ff[0];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctrl.load) begin
         for (int i = 0; i < skcr_pkg::NumKeyWords; i++) begin
            win_in[i] = key[i];
         end
         for (int i = 0; i < skcr_pkg::NumMsgWords; i++) begin
            win_in[skcr_pkg::NumKeyWords + i] = msg[i];
         end
         win_in[9] = skcr_pkg::PadWord;
         for (int i = 10; i < 15; i++) begin
            win_in[i] = '0;
         end
         win_in[15] = skcr_pkg::LengthWord;
      end else if (ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = next_word;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

FILE: rtl/skcr_round.sv
// SHA-1 round unit: working variables and the shared round adder.
module skcr_round (
   input  logic                clock,
   input  logic                reset,
   input  skcr_pkg::ctrl_type  ctrl,
   input  skcr_pkg::word_type  sched_word,
   output skcr_pkg::chain_type work
);

   skcr_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   skcr_pkg::word_type a_in, b_in, c_in, d_in, e_in;
   skcr_pkg::word_type f;
   skcr_pkg::word_type temp;

   always_comb begin
      case (ctrl.phase)
         skcr_pkg::PHASE_CHOOSE:   f = (b_ff & c_ff) ^ (~b_ff & d_ff);
         skcr_pkg::PHASE_MAJORITY: f = (b_ff & c_ff) ^ (b_ff & d_ff) ^ (c_ff & d_ff);
         default:                  f = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign temp = {a_ff[26:0], a_ff[31:27]} + f + e_ff
                 + skcr_pkg::round_constant(ctrl.phase) + sched_word;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctrl.load) begin
         a_in = skcr_pkg::InitChain[0];
         b_in = skcr_pkg::InitChain[1];
         c_in = skcr_pkg::InitChain[2];
         d_in = skcr_pkg::InitChain[3];
         e_in = skcr_pkg::InitChain[4];
      end else if (ctrl.step) begin
         a_in = temp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= '0;
         e_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   assign work[0] = a_ff;
   assign work[1] = b_ff;
   assign work[2] = c_ff;
   assign work[3] = d_ff;
   assign work[4] = e_ff;

endmodule

FILE: rtl/sha1_keyed_challenge_response.sv
// Top level of the keyed two-pass SHA-1 challenge/response engine.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_challenge_word0..4
//   rsp_      out        rsp_valid/rsp_ready  rsp_digest_word0..4
//   csr_      in         csr_wr_en            csr_index, csr_wr_data
//
// The first block is loaded in the accepting cycle; after it come the first pass's rounds, a
// finishing state that ends the first pass and reloads, the second pass's rounds and a final
// finishing state that hands the digest to rsp_; a new transaction is taken only from idle.
// The single round adder computes one round per cycle.
// req_ready is high only while idle; a finished digest waits in the output register,
// and the engine stays in its final finishing state while that register is full and not read.
// Reset is synchronous and active high; it restores the key registers to their defaults.
`include "sha1_keyed_challenge_response_defines.svh"

module sha1_keyed_challenge_response (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          req_challenge_word0,
   input  logic [31:0]                          req_challenge_word1,
   input  logic [31:0]                          req_challenge_word2,
   input  logic [31:0]                          req_challenge_word3,
   input  logic [31:0]                          req_challenge_word4,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [31:0]                          rsp_digest_word0,
   output logic [31:0]                          rsp_digest_word1,
   output logic [31:0]                          rsp_digest_word2,
   output logic [31:0]                          rsp_digest_word3,
   output logic [31:0]                          rsp_digest_word4,
   input  logic                                 csr_wr_en,
   input  logic [skcr_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [31:0]                          csr_wr_data
);

   skcr_pkg::state_type state_ff, state_in;
   skcr_pkg::round_type round_count_ff, round_count_in;
   logic                second_pass_ff, second_pass_in;
   logic                rsp_valid_ff, rsp_valid_in;
   skcr_pkg::chain_type rsp_data_ff;
   skcr_pkg::key_type   key_ff, key_in;

   skcr_pkg::ctrl_type  ctrl;
   skcr_pkg::chain_type challenge;
   skcr_pkg::chain_type load_msg;
   skcr_pkg::chain_type work;
   skcr_pkg::chain_type digest;
   skcr_pkg::word_type  sched_word;
   logic                slot_free;
   logic                deliver;
   logic                in_rounds;
   logic                first_pass_start;
   logic                second_finished;

   assign challenge[0] = req_challenge_word0;
   assign challenge[1] = req_challenge_word1;
   assign challenge[2] = req_challenge_word2;
   assign challenge[3] = req_challenge_word3;
   assign challenge[4] = req_challenge_word4;

   always_comb begin
      for (int i = 0; i < skcr_pkg::NumMsgWords; i++) begin
         digest[i] = skcr_pkg::InitChain[i] + work[i];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Configuration writes; indexes beyond the key words are dropped.
   always_comb begin
      key_in = key_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            skcr_pkg::CSR_KEY_WORD0: key_in[0] = csr_wr_data;
            skcr_pkg::CSR_KEY_WORD1: key_in[1] = csr_wr_data;
            skcr_pkg::CSR_KEY_WORD2: key_in[2] = csr_wr_data;
            skcr_pkg::CSR_KEY_WORD3: key_in[3] = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skcr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = skcr_pkg::ST_ROUND;
            end
         end
         skcr_pkg::ST_ROUND: begin
            if (round_count_ff == skcr_pkg::LastRound) begin
               state_in = skcr_pkg::ST_FINISH;
            end
         end
         skcr_pkg::ST_FINISH: begin
            if (!second_pass_ff) begin
               state_in = skcr_pkg::ST_ROUND;
            end else if (slot_free) begin
               state_in = skcr_pkg::ST_IDLE;
            end
         end
         default: state_in = skcr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.step  = 1'b0;
      load_msg   = challenge;
      deliver    = 1'b0;
      unique case (state_ff)
         skcr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         skcr_pkg::ST_ROUND: begin
            ctrl.step = 1'b1;
         end
         skcr_pkg::ST_FINISH: begin
            // The first digest becomes the message of the second pass.
            load_msg  = digest;
            ctrl.load = !second_pass_ff;
            deliver   = second_pass_ff && slot_free;
         end
         default: ;
      endcase

      if (round_count_ff < skcr_pkg::ParityStart) begin
         ctrl.phase = skcr_pkg::PHASE_CHOOSE;
      end else if (round_count_ff < skcr_pkg::MajorityStart) begin
         ctrl.phase = skcr_pkg::PHASE_PARITY;
      end else if (round_count_ff < skcr_pkg::LateStart) begin
         ctrl.phase = skcr_pkg::PHASE_MAJORITY;
      end else begin
         ctrl.phase = skcr_pkg::PHASE_PARITY_LATE;
      end
   end

   always_comb begin
      round_count_in = '0;
      if (state_ff == skcr_pkg::ST_ROUND && round_count_ff != skcr_pkg::LastRound) begin
         round_count_in = round_count_ff + 7'd1;
      end

      second_pass_in = second_pass_ff;
      if (state_ff == skcr_pkg::ST_FINISH) begin
         if (!second_pass_ff) begin
            second_pass_in = 1'b1;
         end else if (slot_free) begin
            second_pass_in = 1'b0;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= skcr_pkg::ST_IDLE;
         round_count_ff <= '0;
         second_pass_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         key_ff         <= skcr_pkg::KeyReset;
      end else begin
         state_ff       <= state_in;
         round_count_ff <= round_count_in;
         second_pass_ff <= second_pass_in;
         rsp_valid_ff   <= rsp_valid_in;
         key_ff         <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_data_ff <= digest;
      end
   end

   skcr_schedule u_schedule (
      .clock      (clock),
      .ctrl       (ctrl),
      .key        (key_ff),
      .msg        (load_msg),
      .sched_word (sched_word)
   );

   skcr_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sched_word (sched_word),
      .work       (work)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word0 = rsp_data_ff[0];
   assign rsp_digest_word1 = rsp_data_ff[1];
   assign rsp_digest_word2 = rsp_data_ff[2];
   assign rsp_digest_word3 = rsp_data_ff[3];
   assign rsp_digest_word4 = rsp_data_ff[4];

   assign in_rounds        = state_ff == skcr_pkg::ST_ROUND;
   assign first_pass_start = in_rounds && round_count_ff == '0 && !second_pass_ff;
   assign second_finished  = second_pass_ff && state_ff == skcr_pkg::ST_FINISH;

   // An accepted transaction starts the first pass at round zero.
   `SKCR_ASSERT_NEXT(a_start_first_pass, clock, reset, req_valid && req_ready, first_pass_start)

   // The round counter is only non-zero while rounds are running.
   `SKCR_ASSERT_SAME(a_count_idle_zero, clock, reset, !in_rounds, round_count_ff == '0)

   // A new digest is only presented after the second pass has finished.
   `SKCR_ASSERT_SAME(a_result_after_second, clock, reset, $rose(rsp_valid_ff), $past(second_finished))

endmodule
